FILE: rtl/sbq_pkg.sv
// Shared types and constants for the stereo biquad filter.
package sbq_pkg;

  localparam int SAMPLE_W            = 24;
  localparam int COEF_W              = 32;
  localparam int COEF_FRAC_BITS_DEF  = 28;
  localparam int CFG_IDX_W           = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_B0 = 3'd0,
    REG_B1 = 3'd1,
    REG_B2 = 3'd2,
    REG_A1 = 3'd3,
    REG_A2 = 3'd4
  } sbq_reg_e;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_in;
    logic signed [SAMPLE_W-1:0] right_in;
    logic                       frame_last;
  } sbq_in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_out;
    logic signed [SAMPLE_W-1:0] right_out;
    logic                       clipped;
    logic                       out_last;
  } sbq_out_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] b0;
    logic signed [COEF_W-1:0] b1;
    logic signed [COEF_W-1:0] b2;
    logic signed [COEF_W-1:0] a1;
    logic signed [COEF_W-1:0] a2;
  } sbq_coef_t;

  // Pipeline load strobes shared by both lanes
  typedef struct packed {
    logic load_in;
    logic load_sum;
    logic load_out;
  } sbq_lane_ctrl_t;

endpackage

FILE: rtl/sbq_coef_regs.sv
// Coefficient register file written through the configuration port.
module sbq_coef_regs
  import sbq_pkg::*;
#(
  parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COEF_W-1:0]    cfg_data,
  output sbq_coef_t            coef
);

  localparam logic signed [COEF_W-1:0] B0_RESET = COEF_W'(64'd1 << COEF_FRAC_BITS);

  sbq_coef_t coef_r;
  sbq_coef_t coef_nxt;

  assign cfg_ready = 1'b1;
  assign coef      = coef_r;

  always_comb begin
    coef_nxt = coef_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_B0:  coef_nxt.b0 = cfg_data;
        REG_B1:  coef_nxt.b1 = cfg_data;
        REG_B2:  coef_nxt.b2 = cfg_data;
        REG_A1:  coef_nxt.a1 = cfg_data;
        REG_A2:  coef_nxt.a2 = cfg_data;
        default: coef_nxt = coef_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r.b0 <= B0_RESET;
      coef_r.b1 <= '0;
      coef_r.b2 <= '0;
      coef_r.a1 <= '0;
      coef_r.a2 <= '0;
    end else begin
      coef_r <= coef_nxt;
    end
  end

endmodule

FILE: rtl/sbq_lane.sv
// One channel of the direct-form-I biquad: feedforward pipeline plus feedback stage.
module sbq_lane
  import sbq_pkg::*;
#(
  parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  sbq_lane_ctrl_t             ctrl,
  input  sbq_coef_t                  coef,
  input  logic signed [SAMPLE_W-1:0] x,
  output logic signed [SAMPLE_W-1:0] y,
  output logic                       sat
);

  localparam int PROD_W = SAMPLE_W + COEF_W;
  localparam int ACC_W  = PROD_W + 3;

  localparam logic signed [ACC_W-1:0] RND =
    {{(ACC_W-1){1'b0}}, 1'b1} << (COEF_FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0] Y_HI =
    {{(ACC_W-SAMPLE_W+1){1'b0}}, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] Y_LO = ~Y_HI;

  // input history (raw samples)
  logic signed [SAMPLE_W-1:0] xd1_r, xd2_r;
  // feedforward products and their sum
  logic signed [PROD_W-1:0]   p0_r, p1_r, p2_r;
  logic signed [PROD_W-1:0]   p0_nxt, p1_nxt, p2_nxt;
  logic signed [ACC_W-1:0]    ff_r, ff_nxt;
  // output history (saturated results)
  logic signed [SAMPLE_W-1:0] y1_r, y2_r, y_nxt;
  logic signed [PROD_W-1:0]   q1, q2_r, q2_nxt;
  logic signed [ACC_W-1:0]    acc, acc_sh;
  logic                       sat_r, sat_hi, sat_lo;

  assign p0_nxt = coef.b0 * x;
  assign p1_nxt = coef.b1 * xd1_r;
  assign p2_nxt = coef.b2 * xd2_r;
  assign ff_nxt = ACC_W'(p0_r) + ACC_W'(p1_r) + ACC_W'(p2_r) + RND;

  // a2 term for the next item in the output stage is precomputed each cycle
  assign q2_nxt = coef.a2 * (ctrl.load_out ? y1_r : y2_r);
  assign q1     = coef.a1 * y1_r;

  assign acc    = ff_r - ACC_W'(q1) - ACC_W'(q2_r);
  assign acc_sh = acc >>> COEF_FRAC_BITS;
  assign sat_hi = acc_sh > Y_HI;
  assign sat_lo = acc_sh < Y_LO;

  always_comb begin
    if (sat_hi) begin
      y_nxt = Y_HI[SAMPLE_W-1:0];
    end else if (sat_lo) begin
      y_nxt = Y_LO[SAMPLE_W-1:0];
    end else begin
      y_nxt = acc_sh[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xd1_r <= '0;
      xd2_r <= '0;
      y1_r  <= '0;
      y2_r  <= '0;
      q2_r  <= '0;
      sat_r <= 1'b0;
    end else begin
      q2_r <= q2_nxt;
      if (ctrl.load_in) begin
        xd1_r <= x;
        xd2_r <= xd1_r;
      end
      if (ctrl.load_out) begin
        y1_r  <= y_nxt;
        y2_r  <= y1_r;
        sat_r <= sat_hi | sat_lo;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_in) begin
      p0_r <= p0_nxt;
      p1_r <= p1_nxt;
      p2_r <= p2_nxt;
    end
    if (ctrl.load_sum) begin
      ff_r <= ff_nxt;
    end
  end

  assign y   = y1_r;
  assign sat = sat_r;

endmodule

FILE: rtl/stereo_biquad_filter_top.sv
// Stereo direct-form-I biquad filter: two channel lanes, shared coefficients.
// The input passes the product, sum and output registers before out_valid
// rises, and a stall can hold it in any of them. Throughput: one frame per
// cycle while out_stall does not hold the pipeline; the feedback loop is one
// a1 multiply plus the subtract, shift and clamp in the output stage of each lane.
// Reset (synchronous, rst_n low): history cleared, b0 = 1.0, other coefs 0,
// pipeline emptied.
module stereo_biquad_filter_top
  import sbq_pkg::*;
#(
  parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  sbq_in_t              in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output sbq_out_t             out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COEF_W-1:0]    cfg_data
);

  sbq_coef_t      coef;
  sbq_lane_ctrl_t ctrl;

  logic v1_r, v2_r, out_valid_r;
  logic last1_r, last2_r, last_out_r;
  logic en1, en2, en_out;
  logic signed [SAMPLE_W-1:0] y_left, y_right;
  logic sat_left, sat_right;

  // each stage advances when the stage after it is empty or moving
  assign en_out = !out_valid_r || !out_stall;
  assign en2    = !v2_r || en_out;
  assign en1    = !v1_r || en2;

  assign ctrl.load_in  = in_valid && en1;
  assign ctrl.load_sum = v1_r && en2;
  assign ctrl.load_out = v2_r && en_out;

  assign in_stall = !en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en1) begin
        v1_r <= in_valid;
      end
      if (en2) begin
        v2_r <= v1_r;
      end
      if (en_out) begin
        out_valid_r <= v2_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_in) begin
      last1_r <= in_data.frame_last;
    end
    if (ctrl.load_sum) begin
      last2_r <= last1_r;
    end
    if (ctrl.load_out) begin
      last_out_r <= last2_r;
    end
  end

  sbq_coef_regs #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_coef_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .coef      (coef)
  );

  sbq_lane #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_lane_left (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (ctrl),
    .coef  (coef),
    .x     (in_data.left_in),
    .y     (y_left),
    .sat   (sat_left)
  );

  sbq_lane #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_lane_right (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (ctrl),
    .coef  (coef),
    .x     (in_data.right_in),
    .y     (y_right),
    .sat   (sat_right)
  );

  // merge the two lanes into one result transaction
  assign out_valid          = out_valid_r;
  assign out_data.left_out  = y_left;
  assign out_data.right_out = y_right;
  assign out_data.clipped   = sat_left | sat_right;
  assign out_data.out_last  = last_out_r;

endmodule
